// ===== design/fixed_pool_free_list_allocator_unit_macros.svh =====
// Assertion macros shared by the free-list allocator RTL.
// Simulation builds get the checks; synthesis builds define SYNTH and get empty bodies.
`ifndef FIXED_POOL_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_POOL_FREE_LIST_ALLOCATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define FPA_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator check failed");
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator check failed");
`else
`define FPA_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FPA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/fpa_pkg.sv =====
// Package for the free-list allocator: field widths, action and status codes.
// No dependencies.
package fpa_pkg;
   localparam int SLOT_W   = 10;
   localparam int COUNT_W  = 11;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INIT  = 2'd0,
      ACT_ALLOC = 2'd1,
      ACT_FREE  = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_BAD_INDEX = 2'd2
   } status_type;
endpackage

// ===== design/fpa_link_ram.sv =====
// Link store of the allocator: one write port and one registered read port.
// No dependencies.
module fpa_link_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/fixed_pool_free_list_allocator_unit.sv =====
// Per item: allocate passes S_READ then S_DONE (only S_DONE when the pool is empty);
// free and no-op pass S_DONE; initialise walks S_INIT, one link per cycle, then S_DONE.
// One item is in work at a time: items are taken only in S_IDLE, and S_DONE holds while
// the reply output is stalled. The registered read port of the link memory is why an
// allocate needs S_READ. Reset clears head, count and control state; links are undefined
// until an initialise item. Uses fpa_pkg, fpa_link_ram and the assertion macro header.
`include "fixed_pool_free_list_allocator_unit_macros.svh"
module fixed_pool_free_list_allocator_unit
   import fpa_pkg::*;
#(
   parameter int POOL_SLOTS = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] free_slot, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [9:0] slot_index, [20:10] slots_in_use, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   localparam int AW = $clog2(POOL_SLOTS);
   localparam int LW = $clog2(POOL_SLOTS + 1);
   localparam logic [LW-1:0] POOL_END  = LW'(POOL_SLOTS);
   localparam logic [AW-1:0] LAST_SLOT = AW'(POOL_SLOTS - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_READ,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   logic [LW-1:0]         head_ff, head_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [AW-1:0]         walk_ff, walk_in;
   logic [SLOT_W-1:0]     res_slot_ff, res_slot_in;
   status_type            res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]     rsp_slot_ff, rsp_slot_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  req_fire;
   logic [SLOT_W-1:0]     req_free_slot;
   logic [ACTION_W-1:0]   req_action;
   logic                  head_empty;
   logic                  idx_ok;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [LW-1:0]         wr_data;
   logic [LW-1:0]         rd_data;

   assign req_free_slot = req_tdata[SLOT_W-1:0];
   assign req_action    = req_tuser;
   assign req_tready    = (state_ff == S_IDLE);
   assign req_fire      = req_tvalid && req_tready;
   assign head_empty    = (head_ff >= POOL_END);
   assign idx_ok        = (32'(req_free_slot) < 32'(POOL_SLOTS));

   fpa_link_ram #(
      .DEPTH (POOL_SLOTS),
      .AW    (AW),
      .DW    (LW)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (AW'(head_ff)),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = walk_ff;
      wr_data       = LW'(walk_ff) + LW'(1);
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               res_slot_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               case (req_action)
                  ACT_INIT: begin
                     walk_in  = '0;
                     state_in = S_INIT;
                  end
                  ACT_ALLOC: begin
                     if (head_empty) begin
                        res_status_in = ST_EXHAUSTED;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  ACT_FREE: begin
                     if (!idx_ok) begin
                        res_status_in = ST_BAD_INDEX;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_free_slot);
                        wr_data = head_ff;
                        head_in = LW'(req_free_slot);
                        if (count_ff != '0) begin
                           count_in = count_ff - COUNT_W'(1);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INIT: begin
            wr_en   = 1'b1;
            walk_in = walk_ff + AW'(1);
            if (walk_ff == LAST_SLOT) begin
               head_in  = '0;
               count_in = '0;
               state_in = S_DONE;
            end
         end
         S_READ: begin
            head_in     = rd_data;
            res_slot_in = SLOT_W'(head_ff);
            if (count_ff != COUNT_MAX) begin
               count_in = count_ff + COUNT_W'(1);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_slot_in   = res_slot_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = count_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      walk_ff       <= walk_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_count_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   `FPA_ASSERT_NEXT(a_exhausted_holds_head, clock, reset,
      req_fire && req_action == ACT_ALLOC && head_empty,
      state_ff == S_DONE && res_status_ff == ST_EXHAUSTED && $stable(head_ff))
   `FPA_ASSERT_NEXT(a_walk_end_clears, clock, reset,
      state_ff == S_INIT && walk_ff == LAST_SLOT,
      state_ff == S_DONE && head_ff == '0 && count_ff == '0)
   `FPA_ASSERT_IMPLIES(a_result_from_done, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff) == S_DONE)
endmodule
